// File: sv/lscp_pkg.sv
// Shared types and constants of the LRU slot cache policy block.
package lscp_pkg;

  // Request clock saturates here, so stamps fit in 31 bits.
  localparam int unsigned STAMP_W = 31;
  localparam logic [STAMP_W-1:0] CLOCK_MAX = 31'h7fff_ffff;

  // Width of the slot field in a result transfer.
  localparam int unsigned SLOT_OUT_W = 4;

  // Request modes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_FILL   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } lscp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the request and restart the scan
    logic issue;   // read the slot at the scan address and advance it
    logic commit;  // write back the decision and load the result register
  } lscp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_addr;  // the scan address points at the last slot
    logic out_busy;   // the result register holds a result that is not taken
  } lscp_status_t;

endpackage

// File: sv/lscp_if.sv
// Request and result channel interfaces of the LRU slot cache policy block.
interface lscp_req_if #(
  parameter int unsigned KEY_BITS = 32
) ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface lscp_rsp_if ();
  import lscp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  replaced;

  modport source (output valid, output hit, output slot, output replaced, input ready);
  modport sink (input valid, input hit, input slot, input replaced, output ready);
endinterface

// File: sv/lscp_ctrl.sv
// Controller state machine that sequences the slot scan and the writeback.
module lscp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lscp_pkg::lscp_status_t status_i,
  output lscp_pkg::lscp_cmd_t    cmd_o
);
  import lscp_pkg::*;

  lscp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The compare of the last slot completes in this cycle.
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/lscp_datapath.sv
// Slot storage, scan compare pipeline, replacement decision and result register.
module lscp_datapath #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lscp_pkg::lscp_cmd_t             cmd_i,
  output lscp_pkg::lscp_status_t          status_o,
  input  logic                            mode_i,
  input  logic [KEY_BITS-1:0]             key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [lscp_pkg::SLOT_OUT_W-1:0] slot_o,
  output logic                            replaced_o
);
  import lscp_pkg::*;

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Slot storage: keys and stamps in memories, valid bits in flip-flops.
  logic [KEY_BITS-1:0] key_mem   [SLOTS];
  logic [STAMP_W-1:0]  stamp_mem [SLOTS];
  logic [SLOTS-1:0]    valid_q;

  // Request clock and latched request.
  logic [STAMP_W-1:0]  clock_q;
  logic                mode_q;
  logic [KEY_BITS-1:0] key_q;

  // Scan pipeline.
  logic [SLOT_W-1:0]   addr_q;
  logic                cmp_vld_q;
  logic [SLOT_W-1:0]   cmp_idx_q;
  logic [KEY_BITS-1:0] rd_key_q;
  logic [STAMP_W-1:0]  rd_stamp_q;

  // Scan trackers.
  logic                match_q;
  logic [SLOT_W-1:0]   match_idx_q;
  logic                empty_q;
  logic [SLOT_W-1:0]   empty_idx_q;
  logic [STAMP_W-1:0]  least_q;
  logic [SLOT_W-1:0]   least_idx_q;

  // Result register.
  logic                out_valid_q;
  logic                hit_q;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic                replaced_q;

  logic                cmp_valid;
  logic                cmp_match;
  logic                cmp_empty;
  logic                cmp_least;
  logic [SLOT_W-1:0]   pick;
  logic                stamp_we;
  logic [SLOT_W-1:0]   stamp_waddr;

  assign cmp_valid = valid_q[cmp_idx_q];
  assign cmp_match = cmp_vld_q && cmp_valid && (rd_key_q == key_q);
  assign cmp_empty = cmp_vld_q && !cmp_valid && !empty_q;
  assign cmp_least = cmp_vld_q && ((cmp_idx_q == '0) || (rd_stamp_q < least_q));

  assign pick        = empty_q ? empty_idx_q : least_idx_q;
  assign stamp_we    = cmd_i.commit && ((mode_q == MODE_FILL) || match_q);
  assign stamp_waddr = (mode_q == MODE_FILL) ? pick : match_idx_q;

  assign status_o.last_addr = (addr_q == LAST_SLOT);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // Memories: one registered read at the scan address, one write at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_key_q   <= key_mem[addr_q];
      rd_stamp_q <= stamp_mem[addr_q];
    end
    if (cmd_i.commit && (mode_q == MODE_FILL)) begin
      key_mem[pick] <= key_q;
    end
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= clock_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      clock_q     <= '0;
      addr_q      <= '0;
      cmp_vld_q   <= 1'b0;
      match_q     <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        addr_q  <= '0;
        match_q <= 1'b0;
        empty_q <= 1'b0;
        if ((mode_i == MODE_LOOKUP) && (clock_q != CLOCK_MAX)) begin
          clock_q <= clock_q + 1'b1;
        end
      end else begin
        if (cmd_i.issue) begin
          addr_q <= addr_q + 1'b1;
        end
        if (cmp_match) begin
          match_q <= 1'b1;
        end
        if (cmp_empty) begin
          empty_q <= 1'b1;
        end
      end
      if (cmd_i.commit && (mode_q == MODE_FILL)) begin
        valid_q[pick] <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_i;
    end
    if (cmp_match) begin
      match_idx_q <= cmp_idx_q;
    end
    if (cmp_empty) begin
      empty_idx_q <= cmp_idx_q;
    end
    if (cmp_least) begin
      least_q     <= rd_stamp_q;
      least_idx_q <= cmp_idx_q;
    end
    if (cmd_i.issue) begin
      cmp_idx_q <= addr_q;
    end
    if (cmd_i.commit) begin
      if (mode_q == MODE_FILL) begin
        hit_q      <= 1'b0;
        slot_q     <= SLOT_OUT_W'(pick);
        replaced_q <= !empty_q;
      end else begin
        hit_q      <= match_q;
        slot_q     <= match_q ? SLOT_OUT_W'(match_idx_q) : '0;
        replaced_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign slot_o      = slot_q;
  assign replaced_o  = replaced_q;

endmodule

// File: sv/lru_slot_cache_policy.sv
// Top level of the fully associative LRU slot cache replacement policy.
//
// The block decides where a cache keeps an object that is named by a key tag.
// A request transfer on req_i carries a mode and a key. A lookup advances the
// request clock (saturating at 0x7fffffff), searches every valid slot for the
// key, and on a hit stamps the highest matching slot with the clock. A fill
// writes the key into the first empty slot, or else into the slot with the
// least stamp (lowest index on ties), and stamps it. Each request produces
// exactly one result transfer on rsp_o with hit, slot and replaced.
//
// Timing: the slots are scanned one per cycle through a registered memory
// read; the scan is followed by the drain of the last compare and then the
// writeback, and a new request is taken only once the previous one has been
// written back.
// A result waits in an output register; the next request is taken and
// scanned meanwhile, and only its writeback waits while the receiver stalls.
// Reset empties every slot and clears the request clock at once; the block
// is ready for a request as soon as reset is released.
module lru_slot_cache_policy #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  lscp_req_if.sink    req_i,
  lscp_rsp_if.source  rsp_o
);
  import lscp_pkg::*;

  lscp_cmd_t    cmd;
  lscp_status_t status;
  logic         in_ready;

  assign req_i.ready = in_ready;

  // The controller sequences load, scan, drain and writeback.
  lscp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the slots and the result register.
  lscp_datapath #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_i      (req_i.mode),
    .key_i       (req_i.key),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .hit_o       (rsp_o.hit),
    .slot_o      (rsp_o.slot),
    .replaced_o  (rsp_o.replaced)
  );

endmodule

// File: sv/lscp_checker.sv
// Port-level assertions for the LRU slot cache policy block and their binding.
module lscp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic                            rsp_hit_i,
  input logic [lscp_pkg::SLOT_OUT_W-1:0] rsp_slot_i,
  input logic                            rsp_replaced_i
);

  // A stalled result keeps its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i)
      && $stable(rsp_slot_i) && $stable(rsp_replaced_i))
    else $error("result changed while stalled");

  // A result never reports both a hit and an eviction.
  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_replaced_i))
    else $error("result reports hit and eviction together");

  // After a request transfer the block is busy scanning.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken during a scan");

  // A new result appears only after a writeback cycle in which no request is taken.
  a_rsp_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result appeared without a preceding scan");

endmodule

bind lru_slot_cache_policy lscp_checker u_lscp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_hit_i      (rsp_o.hit),
  .rsp_slot_i     (rsp_o.slot),
  .rsp_replaced_i (rsp_o.replaced)
);
